@@ hdl/utok_pkg.sv @@
// ----------------------------------------------------------------------------
// utok_pkg
// shared types, codes and the symbol rom for the utf-8 phoneme tokenizer
// ----------------------------------------------------------------------------
package utok_pkg;

    localparam int ROM_LEN      = 178;
    localparam int SYMBOL_COUNT = 178;
    localparam int SEARCH_LEN   = (SYMBOL_COUNT < ROM_LEN) ? SYMBOL_COUNT : ROM_LEN;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_VOCAB_SIZE  = 1'b0;
    localparam logic CFG_TOKEN_LIMIT = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_UTF8     = 2'd1;
    localparam logic [1:0] ST_NOT_IN_VOCAB = 2'd2;
    localparam logic [1:0] ST_OVER_LIMIT   = 2'd3;

    localparam logic [8:0]  VOCAB_SIZE_RST  = 9'd178;
    localparam logic [15:0] TOKEN_LIMIT_RST = 16'd512;

    typedef struct packed {
        logic       err;
        logic [1:0] status;
        logic [7:0] id;
        logic       lead;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       found;
        logic [7:0] id;
    } t_lookup;

    localparam logic [20:0] SYM_ROM [ROM_LEN] = '{
        21'h5F,
        21'h3B, 21'h3A, 21'h2C, 21'h2E, 21'h21, 21'h3F, 21'hA1, 21'hBF, 21'h2014, 21'h2026,
        21'h22, 21'hAB, 21'hBB, 21'h201C, 21'h201D, 21'h20,
        21'h41, 21'h42, 21'h43, 21'h44, 21'h45, 21'h46, 21'h47, 21'h48, 21'h49,
        21'h4A, 21'h4B, 21'h4C, 21'h4D,
        21'h4E, 21'h4F, 21'h50, 21'h51, 21'h52, 21'h53, 21'h54, 21'h55, 21'h56,
        21'h57, 21'h58, 21'h59, 21'h5A,
        21'h61, 21'h62, 21'h63, 21'h64, 21'h65, 21'h66, 21'h67, 21'h68, 21'h69,
        21'h6A, 21'h6B, 21'h6C, 21'h6D,
        21'h6E, 21'h6F, 21'h70, 21'h71, 21'h72, 21'h73, 21'h74, 21'h75, 21'h76,
        21'h77, 21'h78, 21'h79, 21'h7A,
        21'h251, 21'h250, 21'h252, 21'hE6, 21'h253, 21'h299, 21'h3B2, 21'h254,
        21'h255, 21'hE7,
        21'h257, 21'h256, 21'hF0, 21'h2A4, 21'h259, 21'h258, 21'h25A, 21'h25B,
        21'h25C, 21'h25D,
        21'h25E, 21'h25F, 21'h284, 21'h261, 21'h260, 21'h262, 21'h29B, 21'h266,
        21'h267, 21'h127,
        21'h265, 21'h29C, 21'h268, 21'h26A, 21'h29D, 21'h26D, 21'h26C, 21'h26B,
        21'h26E, 21'h29F,
        21'h271, 21'h26F, 21'h270, 21'h14B, 21'h273, 21'h272, 21'h274, 21'hF8,
        21'h275, 21'h278,
        21'h3B8, 21'h153, 21'h276, 21'h298, 21'h279, 21'h27A, 21'h27E, 21'h27B,
        21'h280, 21'h281,
        21'h27D, 21'h282, 21'h283, 21'h288, 21'h2A7, 21'h289, 21'h28A, 21'h28B,
        21'h2C71, 21'h28C,
        21'h263, 21'h264, 21'h28D, 21'h3C7, 21'h28E, 21'h28F, 21'h291, 21'h290,
        21'h292, 21'h294,
        21'h2A1, 21'h295, 21'h2A2, 21'h1C0, 21'h1C1, 21'h1C2, 21'h1C3, 21'h2C8,
        21'h2CC, 21'h2D0,
        21'h2D1, 21'h2BC, 21'h2B4, 21'h2B0, 21'h2B1, 21'h2B2, 21'h2B7, 21'h2E0,
        21'h2E4, 21'h2DE,
        21'h2193, 21'h2191, 21'h2192, 21'h2197, 21'h2198, 21'h27, 21'h329, 21'h27,
        21'h1D7B
    };

    // parallel compare against every entry, highest matching index wins
    function automatic t_lookup sym_lookup(input logic [20:0] cp);
        t_lookup res;
        res = '0;
        for (int i = 0; i < SEARCH_LEN; i++) begin
            if (SYM_ROM[i] == cp) begin
                res.found = 1'b1;
                res.id    = 8'(i);
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/utok_front.sv @@
// ----------------------------------------------------------------------------
// utok_front
// utf-8 decode, token limit check and symbol lookup; at most one command per byte
// ----------------------------------------------------------------------------
module utok_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_in_valid,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_text,
    input  logic            i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output utok_pkg::t_cmd  o_cmd
);
    import utok_pkg::*;

    logic [8:0]  r_vocab_size;
    logic [15:0] r_token_limit;
    logic [1:0]  r_pending,    n_pending;
    logic [20:0] r_accum,      n_accum;
    logic [15:0] r_tokens,     n_tokens;
    logic        r_discarding, n_discarding;

    logic        accept;
    logic        done;
    logic        fail;
    logic [1:0]  fail_code;
    logic [20:0] cp;
    logic [20:0] shifted;
    logic [1:0]  need;
    logic [16:0] total;
    t_lookup     hit;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign shifted    = {r_accum[14:0], i_text_byte[5:0]};
    assign need       = (r_tokens == 16'd0) ? 2'd3 : 2'd2;
    assign total      = {1'b0, r_tokens} + 17'(need);
    assign hit        = sym_lookup(cp);

    always_comb begin
        n_pending    = r_pending;
        n_accum      = r_accum;
        n_tokens     = r_tokens;
        n_discarding = r_discarding;
        done         = 1'b0;
        fail         = 1'b0;
        fail_code    = ST_BAD_UTF8;
        cp           = 21'd0;
        o_push       = 1'b0;
        o_cmd        = '0;

        if (accept) begin
            if (r_discarding) begin
                if (i_end_of_text) begin
                    n_pending    = 2'd0;
                    n_accum      = 21'd0;
                    n_tokens     = 16'd0;
                    n_discarding = 1'b0;
                end
            end else begin
                if (r_pending == 2'd0) begin
                    priority if (!i_text_byte[7]) begin
                        cp   = {13'd0, i_text_byte};
                        done = 1'b1;
                    end else if (i_text_byte[7:5] == 3'b110) begin
                        n_accum   = {16'd0, i_text_byte[4:0]};
                        n_pending = 2'd1;
                    end else if (i_text_byte[7:4] == 4'b1110) begin
                        n_accum   = {17'd0, i_text_byte[3:0]};
                        n_pending = 2'd2;
                    end else if (i_text_byte[7:3] == 5'b11110) begin
                        n_accum   = {18'd0, i_text_byte[2:0]};
                        n_pending = 2'd3;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (i_text_byte[7:6] != 2'b10) begin
                    fail = 1'b1;
                end else begin
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        cp      = shifted;
                        n_accum = 21'd0;
                        done    = 1'b1;
                    end else begin
                        n_accum = shifted;
                    end
                end

                if (!fail && !done && i_end_of_text) begin
                    fail = 1'b1;
                end

                if (!fail && done) begin
                    priority if (total > {1'b0, r_token_limit}) begin
                        fail      = 1'b1;
                        fail_code = ST_OVER_LIMIT;
                    end else if (!hit.found || ({1'b0, hit.id} >= r_vocab_size)) begin
                        fail      = 1'b1;
                        fail_code = ST_NOT_IN_VOCAB;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.id   = hit.id;
                        o_cmd.lead = (r_tokens == 16'd0);
                        o_cmd.last = i_end_of_text;
                        n_tokens   = total[15:0];
                        if (i_end_of_text) begin
                            n_pending = 2'd0;
                            n_accum   = 21'd0;
                            n_tokens  = 16'd0;
                        end
                    end
                end

                if (fail) begin
                    o_push       = 1'b1;
                    o_cmd        = '0;
                    o_cmd.err    = 1'b1;
                    o_cmd.status = fail_code;
                    o_cmd.last   = 1'b1;
                    n_pending    = 2'd0;
                    n_accum      = 21'd0;
                    n_tokens     = 16'd0;
                    n_discarding = !i_end_of_text;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab_size  <= VOCAB_SIZE_RST;
            r_token_limit <= TOKEN_LIMIT_RST;
            r_pending     <= 2'd0;
            r_accum       <= 21'd0;
            r_tokens      <= 16'd0;
            r_discarding  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOCAB_SIZE:  r_vocab_size  <= i_cfg_data[8:0];
                    CFG_TOKEN_LIMIT: r_token_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pending    <= n_pending;
            r_accum      <= n_accum;
            r_tokens     <= n_tokens;
            r_discarding <= n_discarding;
        end
    end

    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discarding |-> (r_pending == 2'd0) && (r_tokens == 16'd0))
        else $error("discarding with a sequence or tokens still open");

    a_error_discards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.err && !i_end_of_text |=> r_discarding)
        else $error("error mid-string did not start discarding");

endmodule

@@ hdl/utok_queue.sv @@
// ----------------------------------------------------------------------------
// utok_queue
// small command queue between the decode front and the result back
// ----------------------------------------------------------------------------
module utok_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utok_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output utok_pkg::t_cmd  o_cmd
);
    import utok_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

@@ hdl/utok_back.sv @@
// ----------------------------------------------------------------------------
// utok_back
// expands commands to blank/id results or an error status in an output register
// ----------------------------------------------------------------------------
module utok_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  utok_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_token_id,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import utok_pkg::*;

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_ID    = 2'd1;
    localparam logic [1:0] PH_BLANK = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic       r_valid;
    logic [7:0] r_token_id;
    logic [1:0] r_status;
    logic       r_last;

    logic       load;
    logic       final_res;
    logic [1:0] eff_phase;
    logic [7:0] res_id;
    logic [1:0] res_status;
    logic       res_last;

    assign load      = !i_q_empty && (!r_valid || !i_out_stall);
    assign eff_phase = (r_phase == PH_LEAD && !i_cmd.lead) ? PH_ID : r_phase;

    always_comb begin
        res_id     = 8'd0;
        res_status = ST_OK;
        res_last   = 1'b0;
        final_res  = 1'b0;
        n_phase    = r_phase;
        if (i_cmd.err) begin
            res_status = i_cmd.status;
            res_last   = 1'b1;
            final_res  = 1'b1;
        end else begin
            unique case (eff_phase)
                PH_LEAD: n_phase = PH_ID;
                PH_ID: begin
                    res_id  = i_cmd.id;
                    n_phase = PH_BLANK;
                end
                PH_BLANK: begin
                    res_last  = i_cmd.last;
                    final_res = 1'b1;
                end
                default: final_res = 1'b1;
            endcase
        end
        if (final_res) begin
            n_phase = PH_LEAD;
        end
    end

    assign o_pop = load && final_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token_id <= res_id;
            r_status   <= res_status;
            r_last     <= res_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_token_id  = r_token_id;
    assign o_status    = r_status;
    assign o_last      = r_last;

    a_phase_holds_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LEAD) |-> !i_q_empty)
        else $error("mid-command phase with no command queued");

    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_OK) |-> r_last && (r_token_id == 8'd0))
        else $error("status result not final or carries an id");

endmodule

@@ hdl/utf8_phoneme_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// utf8_phoneme_tokenizer_core
// utf-8 phoneme string to symbol id tokens with blanks and error status
// ----------------------------------------------------------------------------
// the first result of a byte passes through the command queue and then the
//   output register before it is valid
// throughput: one result per cycle while not stalled, set by the single output
//   register; an ascii symbol byte gives 2 results, 3 when it opens a string
// front decodes one byte per cycle into a 4-entry command queue unless full
// reset: synchronous active low; clears decode state, queue and output,
//   vocab_size returns to 178 and token_limit to 512
module utf8_phoneme_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_token_id,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import utok_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    utok_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    utok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    utok_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_token_id  (o_token_id),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

@@ verif/tb_utf8_phoneme_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_phoneme_tokenizer_core
// Self-checking bench for the utf-8 phoneme tokenizer. Strings are fed one
// byte per transfer. A built-in decoder model predicts the blank and symbol
// tokens and the error status of every string. Each token leaving the block
// is checked in order against that prediction. Directed strings come first,
// then random strings under several register settings and idle patterns,
// including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_utf8_phoneme_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import utok_pkg::*;

    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic [7:0] id;
        logic [1:0] status;
        logic       last;
    } t_token;

    class token_scoreboard;
        t_token      expected_q[$];
        int          errors;
        logic [8:0]  vocab_size;
        logic [15:0] token_limit;
        logic [1:0]  cont_left;
        logic [20:0] code_acc;
        logic [15:0] emitted;
        logic        dropping;

        function new();
            errors      = 0;
            vocab_size  = VOCAB_SIZE_RST;
            token_limit = TOKEN_LIMIT_RST;
            clear_string();
        endfunction

        function void clear_string();
            cont_left = '0;
            code_acc  = '0;
            emitted   = '0;
            dropping  = 1'b0;
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == CFG_VOCAB_SIZE) begin
                vocab_size = data[8:0];
            end else begin
                token_limit = data;
            end
        endfunction

        function void expect_token(logic [7:0] id, logic [1:0] status, logic last);
            t_token tok;
            tok.id     = id;
            tok.status = status;
            tok.last   = last;
            expected_q.insert(expected_q.size(), tok);
        endfunction

        function void abort_string(logic [1:0] code, logic eot);
            expect_token(8'd0, code, 1'b1);
            clear_string();
            dropping = !eot;
        endfunction

        function int find_symbol(logic [20:0] cp);
            int hit;
            hit = -1;
            for (int i = 0; i < SEARCH_LEN; i++) begin
                if (SYM_ROM[i] == cp) begin
                    hit = i;
                end
            end
            return hit;
        endfunction

        // returns 0 when the byte is dropped after an error
        function bit note_byte(logic [7:0] b, logic eot);
            logic [20:0] cp;
            bit          done;
            int          need;
            int          id;
            cp   = '0;
            done = 1'b0;
            if (dropping) begin
                if (eot) begin
                    clear_string();
                end
                return 1'b0;
            end
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    cp   = {13'd0, b};
                    done = 1'b1;
                end else if ((b & 8'hE0) == 8'hC0) begin
                    code_acc  = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if ((b & 8'hF0) == 8'hE0) begin
                    code_acc  = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else if ((b & 8'hF8) == 8'hF0) begin
                    code_acc  = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    abort_string(ST_BAD_UTF8, eot);
                    return 1'b1;
                end
            end else begin
                if ((b & 8'hC0) != 8'h80) begin
                    abort_string(ST_BAD_UTF8, eot);
                    return 1'b1;
                end
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    cp       = code_acc;
                    code_acc = '0;
                    done     = 1'b1;
                end
            end
            if (!done) begin
                if (eot) begin
                    abort_string(ST_BAD_UTF8, eot);
                end
                return 1'b1;
            end
            need = (emitted == 16'd0) ? 3 : 2;
            if (int'(emitted) + need > int'(token_limit)) begin
                abort_string(ST_OVER_LIMIT, eot);
                return 1'b1;
            end
            id = find_symbol(cp);
            if (id < 0 || id >= int'(vocab_size)) begin
                abort_string(ST_NOT_IN_VOCAB, eot);
                return 1'b1;
            end
            if (emitted == 16'd0) begin
                expect_token(8'd0, ST_OK, 1'b0);
            end
            expect_token(id[7:0], ST_OK, 1'b0);
            expect_token(8'd0, ST_OK, eot);
            emitted = emitted + 16'(need);
            if (eot) begin
                clear_string();
            end
            return 1'b1;
        endfunction

        function void check_result(logic [7:0] id, logic [1:0] status, logic last);
            t_token exp_tok;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected token id=%0d status=%0d last=%0d",
                         $time, id, status, last);
                return;
            end
            exp_tok = expected_q.pop_front();
            if (exp_tok.id !== id || exp_tok.status !== status || exp_tok.last !== last) begin
                errors++;
                $display("%0t: token mismatch exp id=%0d status=%0d last=%0d",
                         $time, exp_tok.id, exp_tok.status, exp_tok.last,
                         " got id=%0d status=%0d last=%0d", id, status, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_token_id;
    logic [1:0]  o_status;
    logic        o_last;

    token_scoreboard sb;
    logic [7:0]      str_q[$];
    int              in_idle_pct;
    int              out_idle_pct;
    bit              hold_req;
    int              random_taken;

    utf8_phoneme_tokenizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_id    (o_token_id),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[utf8_phoneme_tokenizer_core] ERROR");
        $finish;
    end

    // output side: random stall, or a long hold-off on request
    initial begin
        int hold_cnt;
        bit hold_done;
        hold_cnt    = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_token_id, o_status, o_last);
        end
    end

    function automatic void add_byte(logic [7:0] b);
        str_q.insert(str_q.size(), b);
    endfunction

    function automatic void add_symbol(logic [20:0] cp, int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic int utf8_len(logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    // mostly well-formed symbol strings, the rest noise, broken or unknown
    function automatic void make_random_string();
        int          kind;
        int          nsym;
        int          len;
        logic [20:0] cp;
        str_q.delete();
        kind = $urandom_range(0, 99);
        nsym = $urandom_range(1, 4);
        if (kind < 75) begin
            for (int s = 0; s < nsym; s++) begin
                cp  = SYM_ROM[$urandom_range(0, ROM_LEN - 1)];
                len = utf8_len(cp);
                if ($urandom_range(0, 9) == 0 && len < 4) begin
                    len++;
                end
                add_symbol(cp, len);
            end
            if (kind >= 62) begin
                if ($urandom_range(0, 1) == 1 && str_q.size() > 1) begin
                    str_q.delete(str_q.size() - 1);
                end else begin
                    str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom);
                end
            end
        end else if (kind < 87) begin
            repeat (nsym) add_byte(8'($urandom));
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                add_symbol(SYM_ROM[$urandom_range(0, ROM_LEN - 1)], 1 + $urandom_range(0, 1));
            end
            add_symbol(21'($urandom), $urandom_range(2, 4));
        end
    endfunction

    // one string, end of text on its final byte
    task automatic send_str(output int taken);
        taken = 0;
        for (int k = 0; k < str_q.size(); k++) begin
            @(negedge i_clk);
            while ($urandom_range(0, 99) < in_idle_pct) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
            i_in_valid    = 1'b1;
            i_text_byte   = str_q[k];
            i_end_of_text = (k == str_q.size() - 1);
            do @(posedge i_clk); while (o_in_stall);
            if (sb.note_byte(i_text_byte, i_end_of_text)) begin
                taken++;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic start_phase(logic [8:0] vocab, logic [15:0] limit, int in_pct, int out_pct);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_VOCAB_SIZE;
        i_cfg_data  = {7'd0, vocab};
        @(negedge i_clk);
        i_cfg_index = CFG_TOKEN_LIMIT;
        i_cfg_data  = limit;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(CFG_VOCAB_SIZE, {7'd0, vocab});
        sb.set_reg(CFG_TOKEN_LIMIT, limit);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
    endtask

    task automatic run_random(int n);
        int cnt;
        int taken;
        cnt = 0;
        while (cnt < n) begin
            make_random_string();
            send_str(taken);
            cnt += taken;
        end
    endtask

    initial begin
        sb            = new();
        hold_req      = 1'b0;
        in_idle_pct   = 34;
        out_idle_pct  = 56;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_VOCAB_SIZE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed strings at reset register values
        str_q = '{8'h5F};                    send_str(random_taken);
        str_q = '{8'h41, 8'h27};             send_str(random_taken);
        str_q = '{8'hC9, 8'h91};             send_str(random_taken);
        str_q = '{8'hE2, 8'hB1, 8'hB1};      send_str(random_taken);
        str_q = '{8'hC1, 8'hA1};             send_str(random_taken);
        str_q = '{8'hFF};                    send_str(random_taken);
        str_q = '{8'h80, 8'h41};             send_str(random_taken);
        str_q = '{8'hC9, 8'h41};             send_str(random_taken);
        str_q = '{8'hE2, 8'h80};             send_str(random_taken);
        str_q = '{8'h00};                    send_str(random_taken);
        str_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; send_str(random_taken);

        // smallest vocabulary and token limit
        start_phase(9'd1, 16'd3, 34, 56);
        str_q = '{8'h5F, 8'h41};             send_str(random_taken);
        str_q = '{8'h42};                    send_str(random_taken);
        run_random(15);

        start_phase(9'd256, 16'd65535, 34, 56);
        run_random(15);

        start_phase(9'($urandom_range(1, 256)), 16'($urandom_range(3, 12)), 56, 34);
        run_random(15);

        start_phase(9'($urandom_range(100, 178)), 16'd7, 56, 34);
        run_random(15);

        // output held off while a long ascii string keeps coming
        start_phase(9'd178, 16'd512, 0, 0);
        @(posedge i_clk);
        hold_req = 1'b1;
        str_q.delete();
        repeat (30) add_symbol(SYM_ROM[$urandom_range(17, 68)], 1);
        send_str(random_taken);
        run_random(10);

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[utf8_phoneme_tokenizer_core] OK");
        end else begin
            $display("[utf8_phoneme_tokenizer_core] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/utok_pkg.sv
hdl/utok_front.sv
hdl/utok_queue.sv
hdl/utok_back.sv
hdl/utf8_phoneme_tokenizer_core.sv
verif/tb_utf8_phoneme_tokenizer_core.sv
